// File: hdl/tile_background_video_unit_assert.svh
// assertion macros for the tile background video unit
// no dependencies; included by the top level inside its module body
`ifndef TILE_BACKGROUND_VIDEO_UNIT_ASSERT_SVH
`define TILE_BACKGROUND_VIDEO_UNIT_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define TBVU_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define TBVU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tbvu_pkg.sv
// shared types and constants for the tile background video unit
// no dependencies; imported by tile_background_video_unit
package tbvu_pkg;

   // geometry and memory size
   localparam int VRAM_ADDR_BITS = 14;
   localparam int VRAM_DEPTH     = 1 << VRAM_ADDR_BITS;
   localparam int LINE_DOTS      = 341;
   localparam int FRAME_LINES    = 262;

   // visible window and vblank line
   localparam logic [8:0] VISIBLE_DOTS  = 9'd257;
   localparam logic [8:0] VISIBLE_LINES = 9'd240;
   localparam logic [8:0] VBLANK_LINE   = 9'd241;

   // fixed memory map
   localparam logic [15:0] NAMETABLE_BASE = 16'h2000;
   localparam logic [15:0] ATTR_OFFSET    = 16'h03C0;
   localparam logic [15:0] PALETTE_BASE   = 16'h3F00;
   localparam logic [15:0] PATTERN_HIGH   = 16'h1000;

   // request operations
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   // register indexes
   localparam logic [2:0] REG_CTRL   = 3'd0;
   localparam logic [2:0] REG_MASK   = 3'd1;
   localparam logic [2:0] REG_STATUS = 3'd2;
   localparam logic [2:0] REG_ADDR   = 3'd6;
   localparam logic [2:0] REG_DATA   = 3'd7;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_TILE,
      S_ATTR,
      S_PLO,
      S_PHI,
      S_PAL,
      S_RBUF
   } state_type;

endpackage

// File: hdl/tile_background_video_unit.sv
// tile background video unit: sequencer, counters, register file and video memory
// depends on tbvu_pkg and tile_background_video_unit_assert.svh
//
// One request at a time goes through a small sequencer that drives the single
// port of the 16K x 8 video memory (read data registered) through one shared
// address adder. A tile-fetch tick (every eighth visible dot) reads the tile
// id, attribute, two pattern bytes and the palette byte one after another.
// Other visible ticks and data-port reads (register 7) read one byte, and all
// remaining ticks, register reads and writes finish without a memory read.
// A stalled result holds the sequencer in its last step. Video memory is not
// cleared after reset and is ready at once.
module tile_background_video_unit
   import tbvu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [2:0] req_reg_index,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_pixel_valid,
   output logic [7:0] rsp_color_index,
   output logic [7:0] rsp_read_data,
   output logic       rsp_nmi_pulse,
   output logic       rsp_frame_done,
   output logic       rsp_rendering_enabled
);

   state_type state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [2:0]  reg_ff, reg_in;
   logic [7:0]  data_ff, data_in;
   logic [8:0]  dot_ff, dot_in;
   logic [8:0]  line_ff, line_in;
   logic [5:0]  row_ff, row_in;
   logic [7:0]  plo_ff, plo_in;
   logic [7:0]  phi_ff, phi_in;
   logic [1:0]  pal_ff, pal_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [7:0]  mask_ff, mask_in;
   logic        vblank_ff, vblank_in;
   logic        toggle_ff, toggle_in;
   logic [15:0] ptr_ff, ptr_in;
   logic [7:0]  rbuf_ff, rbuf_in;
   logic [7:0]  tile_ff, tile_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_pixel_ff, rsp_pixel_in;
   logic [7:0] rsp_color_ff, rsp_color_in;
   logic [7:0] rsp_rdata_ff, rsp_rdata_in;
   logic       rsp_nmi_ff, rsp_nmi_in;
   logic       rsp_frame_ff, rsp_frame_in;
   logic       rsp_ren_ff, rsp_ren_in;

   // video memory and its single port
   logic [7:0] vram [VRAM_DEPTH];
   logic [7:0] mem_q;
   logic       mem_re, mem_we;
   logic [15:0] addr_base, addr_off, addr_sum;
   logic [VRAM_ADDR_BITS-1:0] mem_addr;

   // result fields of the finishing step
   logic       load_rsp, tick_end;
   logic       res_pixel;
   logic [7:0] res_color, res_rdata;

   // tick bookkeeping
   logic       out_free, visible;
   logic [5:0] cx;
   logic [9:0] dot_inc, line_inc;
   logic [15:0] nt_base, pat_base, ptr_step;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign visible  = (dot_ff < VISIBLE_DOTS) && (line_ff < VISIBLE_LINES);
   assign cx       = dot_ff[8:3];
   assign dot_inc  = {1'b0, dot_ff} + 10'd1;
   assign line_inc = {1'b0, line_ff} + 10'd1;
   assign nt_base  = NAMETABLE_BASE + {4'd0, ctrl_ff[1:0], 10'd0};
   assign pat_base = ctrl_ff[4] ? PATTERN_HIGH : 16'h0000;
   assign ptr_step = ctrl_ff[2] ? 16'd32 : 16'd1;

   // shared address adder
   assign addr_sum = addr_base + addr_off;
   assign mem_addr = addr_sum[VRAM_ADDR_BITS-1:0];

   assign req_stall = (state_ff != S_IDLE);

   // sequencer: next state and register updates
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      reg_in     = reg_ff;
      data_in    = data_ff;
      dot_in     = dot_ff;
      line_in    = line_ff;
      row_in     = row_ff;
      plo_in     = plo_ff;
      phi_in     = phi_ff;
      pal_in     = pal_ff;
      ctrl_in    = ctrl_ff;
      mask_in    = mask_ff;
      vblank_in  = vblank_ff;
      toggle_in  = toggle_ff;
      ptr_in     = ptr_ff;
      rbuf_in    = rbuf_ff;
      tile_in    = tile_ff;
      mem_re     = 1'b0;
      mem_we     = 1'b0;
      addr_base  = 16'h0000;
      addr_off   = 16'h0000;
      load_rsp   = 1'b0;
      tick_end   = 1'b0;
      res_pixel  = 1'b0;
      res_color  = 8'h00;
      res_rdata  = 8'h00;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               reg_in   = req_reg_index;
               data_in  = req_write_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_TICK: begin
                  if (visible && dot_ff[2:0] == 3'd0) begin
                     // tile id at nametable + row * 32 + column
                     addr_base = nt_base;
                     addr_off  = {5'd0, row_ff, 5'd0} + {10'd0, cx};
                     mem_re    = 1'b1;
                     state_in  = S_TILE;
                  end else if (visible) begin
                     addr_base = PALETTE_BASE;
                     addr_off  = {12'd0, pal_ff, phi_ff[7], plo_ff[7]};
                     mem_re    = 1'b1;
                     state_in  = S_PAL;
                  end else if (out_free) begin
                     tick_end = 1'b1;
                     load_rsp = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               OP_READ: begin
                  if (reg_ff == REG_DATA) begin
                     addr_base = ptr_ff;
                     mem_re    = 1'b1;
                     state_in  = S_RBUF;
                  end else if (out_free) begin
                     if (reg_ff == REG_STATUS) begin
                        res_rdata = {vblank_ff, 7'd0};
                        vblank_in = 1'b0;
                        toggle_in = 1'b0;
                     end
                     load_rsp = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               OP_WRITE: begin
                  if (out_free) begin
                     case (reg_ff)
                        REG_CTRL: ctrl_in = data_ff;
                        REG_MASK: mask_in = data_ff;
                        REG_ADDR: begin
                           if (toggle_ff) begin
                              ptr_in = {ptr_ff[15:8], data_ff};
                           end else begin
                              ptr_in = {data_ff, ptr_ff[7:0]};
                           end
                           toggle_in = !toggle_ff;
                        end
                        REG_DATA: begin
                           addr_base = ptr_ff;
                           mem_we    = 1'b1;
                           ptr_in    = ptr_ff + ptr_step;
                        end
                        default: ;
                     endcase
                     load_rsp = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     load_rsp = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_TILE: begin
            // attribute byte for the 4x4 tile block
            tile_in   = mem_q;
            addr_base = nt_base;
            addr_off  = ATTR_OFFSET + {9'd0, row_ff[5:2], 3'd0} + {12'd0, cx[5:2]};
            mem_re    = 1'b1;
            state_in  = S_ATTR;
         end
         S_ATTR: begin
            // pick the quadrant's palette pair, then low pattern plane
            case ({row_ff[1], cx[1]})
               2'd0:    pal_in = mem_q[1:0];
               2'd1:    pal_in = mem_q[3:2];
               2'd2:    pal_in = mem_q[5:4];
               default: pal_in = mem_q[7:6];
            endcase
            addr_base = pat_base;
            addr_off  = {4'd0, tile_ff, 1'b0, line_ff[2:0]};
            mem_re    = 1'b1;
            state_in  = S_PLO;
         end
         S_PLO: begin
            plo_in    = mem_q;
            addr_base = pat_base;
            addr_off  = {4'd0, tile_ff, 1'b1, line_ff[2:0]};
            mem_re    = 1'b1;
            state_in  = S_PHI;
         end
         S_PHI: begin
            phi_in    = mem_q;
            addr_base = PALETTE_BASE;
            addr_off  = {12'd0, pal_ff, mem_q[7], plo_ff[7]};
            mem_re    = 1'b1;
            state_in  = S_PAL;
         end
         S_PAL: begin
            if (out_free) begin
               res_pixel = 1'b1;
               res_color = mem_q;
               plo_in    = {plo_ff[6:0], 1'b0};
               phi_in    = {phi_ff[6:0], 1'b0};
               tick_end  = 1'b1;
               load_rsp  = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_RBUF: begin
            if (out_free) begin
               res_rdata = (ptr_ff >= PALETTE_BASE) ? mem_q : rbuf_ff;
               rbuf_in   = mem_q;
               ptr_in    = ptr_ff + ptr_step;
               load_rsp  = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // end of a tick: vblank flag and dot / line counters
      rsp_nmi_in   = 1'b0;
      rsp_frame_in = 1'b0;
      if (tick_end) begin
         if (line_ff == VBLANK_LINE && dot_ff == 9'd1) begin
            vblank_in  = 1'b1;
            rsp_nmi_in = ctrl_ff[7];
         end else if (line_ff == 9'(FRAME_LINES - 1) && dot_ff == 9'd1) begin
            vblank_in = 1'b0;
         end
         if (dot_inc >= 10'(LINE_DOTS)) begin
            dot_in = 9'd0;
            if (line_inc >= 10'(FRAME_LINES)) begin
               line_in      = 9'd0;
               row_in       = 6'd0;
               rsp_frame_in = 1'b1;
            end else begin
               line_in = line_inc[8:0];
               row_in  = line_inc[8:3];
            end
         end else begin
            dot_in = dot_inc[8:0];
         end
      end

      // result register
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = res_pixel;
         rsp_color_in = res_color;
         rsp_rdata_in = res_rdata;
         rsp_ren_in   = mask_in[3] || mask_in[4];
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_pixel_in = rsp_pixel_ff;
         rsp_color_in = rsp_color_ff;
         rsp_rdata_in = rsp_rdata_ff;
         rsp_ren_in   = rsp_ren_ff;
         rsp_nmi_in   = rsp_nmi_ff;
         rsp_frame_in = rsp_frame_ff;
      end
   end

   // control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dot_ff       <= 9'd0;
         line_ff      <= 9'd0;
         row_ff       <= 6'd0;
         plo_ff       <= 8'd0;
         phi_ff       <= 8'd0;
         pal_ff       <= 2'd0;
         ctrl_ff      <= 8'd0;
         mask_ff      <= 8'd0;
         vblank_ff    <= 1'b0;
         toggle_ff    <= 1'b0;
         ptr_ff       <= 16'd0;
         rbuf_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dot_ff       <= dot_in;
         line_ff      <= line_in;
         row_ff       <= row_in;
         plo_ff       <= plo_in;
         phi_ff       <= phi_in;
         pal_ff       <= pal_in;
         ctrl_ff      <= ctrl_in;
         mask_ff      <= mask_in;
         vblank_ff    <= vblank_in;
         toggle_ff    <= toggle_in;
         ptr_ff       <= ptr_in;
         rbuf_ff      <= rbuf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      reg_ff       <= reg_in;
      data_ff      <= data_in;
      tile_ff      <= tile_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_color_ff <= rsp_color_in;
      rsp_rdata_ff <= rsp_rdata_in;
      rsp_nmi_ff   <= rsp_nmi_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_ren_ff   <= rsp_ren_in;
   end

   // video memory port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vram[mem_addr] <= data_ff;
      end
      if (mem_re) begin
         mem_q <= vram[mem_addr];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_pixel_valid       = rsp_pixel_ff;
   assign rsp_color_index       = rsp_color_ff;
   assign rsp_read_data         = rsp_rdata_ff;
   assign rsp_nmi_pulse         = rsp_nmi_ff;
   assign rsp_frame_done        = rsp_frame_ff;
   assign rsp_rendering_enabled = rsp_ren_ff;

`include "tile_background_video_unit_assert.svh"

   // counters stay inside the frame
   `TBVU_ASSERT_ALWAYS(a_counters_in_frame, clock, reset, (dot_ff < 9'(LINE_DOTS)) && (line_ff < 9'(FRAME_LINES)), "dot or line counter outside the frame")
   // a visible tick that finishes shows up as a pixel
   `TBVU_ASSERT_NEXT(a_pal_gives_pixel, clock, reset, (state_ff == S_PAL) && out_free, rsp_valid_ff && rsp_pixel_ff, "palette step finished without a pixel result")
   // an interrupt pulse is only raised together with the vblank flag
   `TBVU_ASSERT_ALWAYS(a_nmi_with_vblank, clock, reset, !(rsp_valid_ff && rsp_nmi_ff) || vblank_ff, "nmi pulse without vblank flag")

endmodule

// File: tb/sv/tile_background_video_unit_checker.sv
// request/result checker for the tile background video unit: predicts and compares
// depends on tbvu_pkg; instantiated by tb beside the unit
module tile_background_video_unit_checker
   import tbvu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [2:0] req_reg_index,
   input  logic [7:0] req_write_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_pixel_valid,
   input  logic [7:0] rsp_color_index,
   input  logic [7:0] rsp_read_data,
   input  logic       rsp_nmi_pulse,
   input  logic       rsp_frame_done,
   input  logic       rsp_rendering_enabled,
   output int         error_count,
   output int         outstanding
);

   // memory map strides and register bit positions
   localparam int          NAMETABLE_SPAN   = 'h400;
   localparam int          TILE_BYTES       = 16;
   localparam int          PLANE_OFFSET     = 8;
   localparam int          PALETTE_STRIDE   = 4;
   localparam logic [7:0]  STATUS_VBLANK    = 8'h80;
   localparam int          CTRL_INC_BIT     = 2;
   localparam int          CTRL_PATTERN_BIT = 4;
   localparam int          CTRL_NMI_BIT     = 7;
   localparam int          MASK_BG_BIT      = 3;
   localparam int          MASK_SPR_BIT     = 4;
   localparam logic [15:0] STEP_ACROSS      = 16'd1;
   localparam logic [15:0] STEP_DOWN        = 16'd32;

   typedef struct packed {
      logic       pixel;
      logic [7:0] color;
      logic [7:0] rdata;
      logic       nmi;
      logic       frame;
      logic       render;
   } pixel_result_type;

   // shadow of the unit's state
   logic [7:0]  vram_copy [VRAM_DEPTH];
   int          dot_pos;
   int          line_pos;
   int          row_pos;
   logic [7:0]  plane_lo;
   logic [7:0]  plane_hi;
   logic [1:0]  pal_sel;
   logic [7:0]  ctrl_q;
   logic [7:0]  mask_q;
   logic        vblank;
   logic        addr_phase;
   logic [15:0] vram_ptr;
   logic [7:0]  read_buf;

   pixel_result_type awaited_results [$];
   int               err_total = 0;

   assign error_count = err_total;

   function automatic logic [7:0] vram_at(input int addr);
      return vram_copy[addr & (VRAM_DEPTH - 1)];
   endfunction

   task automatic bump_pointer();
      vram_ptr = vram_ptr + (ctrl_q[CTRL_INC_BIT] ? STEP_DOWN : STEP_ACROSS);
   endtask

   // apply one request to the shadow state and work out its result
   task automatic predict_result(input logic [1:0] op, input logic [2:0] idx,
                                 input logic [7:0] wdata, output pixel_result_type res);
      int         col;
      int         nt;
      int         attr_shift;
      int         base;
      logic [7:0] tile_id;
      logic [7:0] attr;
      res = '0;
      case (op)
         OP_TICK: begin
            if (dot_pos < int'(VISIBLE_DOTS) && line_pos < int'(VISIBLE_LINES)) begin
               // tile id, attribute and both pattern planes every eighth dot
               if (dot_pos % 8 == 0) begin
                  col = dot_pos / 8;
                  nt = int'(NAMETABLE_BASE) + int'(ctrl_q[1:0]) * NAMETABLE_SPAN;
                  tile_id = vram_at(nt + col + row_pos * 32);
                  attr = vram_at(nt + int'(ATTR_OFFSET) + col / 4 + (row_pos / 4) * 8);
                  attr_shift = (((row_pos % 4 > 1) ? 2 : 0) + ((col % 4 > 1) ? 1 : 0)) * 2;
                  pal_sel = attr[attr_shift +: 2];
                  base = ctrl_q[CTRL_PATTERN_BIT] ? int'(PATTERN_HIGH) : 0;
                  plane_lo = vram_at(base + int'(tile_id) * TILE_BYTES + line_pos % 8);
                  plane_hi = vram_at(base + int'(tile_id) * TILE_BYTES + PLANE_OFFSET
                                     + line_pos % 8);
               end
               // palette byte from the top bits of both planes
               res.pixel = 1'b1;
               res.color = vram_at(int'(PALETTE_BASE) + int'(pal_sel) * PALETTE_STRIDE
                                   + int'({plane_hi[7], plane_lo[7]}));
               plane_lo = plane_lo << 1;
               plane_hi = plane_hi << 1;
            end
            // vblank set and cleared at dot 1
            if (line_pos == int'(VBLANK_LINE) && dot_pos == 1) begin
               vblank = 1'b1;
               if (ctrl_q[CTRL_NMI_BIT]) res.nmi = 1'b1;
            end else if (line_pos == FRAME_LINES - 1 && dot_pos == 1) begin
               vblank = 1'b0;
            end
            // dot, line and tile row counters
            dot_pos++;
            if (dot_pos >= LINE_DOTS) begin
               dot_pos = 0;
               line_pos++;
               row_pos = (line_pos / 8) % 64;
               if (line_pos >= FRAME_LINES) begin
                  line_pos = 0;
                  row_pos = 0;
                  res.frame = 1'b1;
               end
            end
         end
         OP_READ: begin
            if (idx == REG_STATUS) begin
               res.rdata = vblank ? STATUS_VBLANK : 8'h00;
               vblank = 1'b0;
               addr_phase = 1'b0;
            end else if (idx == REG_DATA) begin
               // buffered read, palette range bypasses the buffer
               res.rdata = read_buf;
               read_buf = vram_at(int'(vram_ptr));
               if (vram_ptr >= PALETTE_BASE) res.rdata = read_buf;
               bump_pointer();
            end
         end
         OP_WRITE: begin
            case (idx)
               REG_CTRL: ctrl_q = wdata;
               REG_MASK: mask_q = wdata;
               REG_ADDR: begin
                  if (addr_phase) vram_ptr[7:0] = wdata;
                  else vram_ptr[15:8] = wdata;
                  addr_phase = !addr_phase;
               end
               REG_DATA: begin
                  vram_copy[int'(vram_ptr) & (VRAM_DEPTH - 1)] = wdata;
                  bump_pointer();
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      res.render = mask_q[MASK_BG_BIT] | mask_q[MASK_SPR_BIT];
   endtask

   task automatic compare_field(input string what, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         err_total++;
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   // watch both channels at every edge
   always @(posedge clock) begin : watch
      pixel_result_type fresh;
      pixel_result_type oldest;
      if (reset) begin
         dot_pos = 0;
         line_pos = 0;
         row_pos = 0;
         plane_lo = '0;
         plane_hi = '0;
         pal_sel = '0;
         ctrl_q = '0;
         mask_q = '0;
         vblank = 1'b0;
         addr_phase = 1'b0;
         vram_ptr = '0;
         read_buf = '0;
         awaited_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_result(req_operation, req_reg_index, req_write_data, fresh);
            awaited_results.push_back(fresh);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               err_total++;
               $display("%0t result mismatch: expected none, actual color %0h read %0h",
                        $time, rsp_color_index, rsp_read_data);
            end else begin
               oldest = awaited_results.pop_front();
               compare_field("pixel_valid", 8'(oldest.pixel), 8'(rsp_pixel_valid));
               compare_field("color_index", oldest.color, rsp_color_index);
               compare_field("read_data", oldest.rdata, rsp_read_data);
               compare_field("nmi_pulse", 8'(oldest.nmi), 8'(rsp_nmi_pulse));
               compare_field("frame_done", 8'(oldest.frame), 8'(rsp_frame_done));
               compare_field("rendering_enabled", 8'(oldest.render),
                             8'(rsp_rendering_enabled));
            end
         end
      end
      outstanding <= awaited_results.size();
   end

endmodule

// File: tb/sv/tb.sv
// testbench top for the tile background video unit: clock, reset, request traffic, verdict
// depends on tbvu_pkg, tile_background_video_unit and tile_background_video_unit_checker
module tb
   import tbvu_pkg::*;
();

   localparam logic [1:0]  OP_IDLE          = 2'd3;
   localparam int          LONG_HOLD_CYCLES = 400;
   localparam int          DRAIN_CYCLES     = 50;
   localparam int          RANDOM_PER_PHASE = 300;
   localparam int          FILL_BURST       = 40;

   // rendered footprint: far fewer than eight lines of ticks, so only tile row 0
   // is fetched; tile ids are kept to 0..3 so only the first 64 pattern bytes count
   localparam int          NAMETABLES       = 4;
   localparam logic [15:0] NAMETABLE_SPAN   = 16'h0400;
   localparam int          ROW_TILES        = 33;
   localparam int          ROW_ATTRS        = 9;
   localparam logic [15:0] PATTERN_LOW      = 16'h0000;
   localparam int          PATTERN_BYTES    = 64;
   localparam int          PALETTE_BYTES    = 16;
   localparam logic [7:0]  TILE_ID_MASK     = 8'h03;

   // scratch area for data port streams, wide enough for eight steps of 32
   localparam logic [15:0] SCRATCH_BASE     = 16'h0400;
   localparam int          SCRATCH_BYTES    = 256;
   localparam int          STREAM_SPREAD    = 31;
   localparam int          STREAM_MAX       = 8;
   localparam logic [15:0] WRAP_ADDR        = 16'hFFF0;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_operation = OP_TICK;
   logic [2:0] req_reg_index = REG_CTRL;
   logic [7:0] req_write_data = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_pixel_valid;
   logic [7:0] rsp_color_index;
   logic [7:0] rsp_read_data;
   logic       rsp_nmi_pulse;
   logic       rsp_frame_done;
   logic       rsp_rendering_enabled;

   int error_count;
   int outstanding;
   int src_idle_pct = 0;
   int sink_idle_pct = 0;
   int hold_asked = 0;
   int hold_served = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tile_background_video_unit DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_reg_index        (req_reg_index),
      .req_write_data       (req_write_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pixel_valid      (rsp_pixel_valid),
      .rsp_color_index      (rsp_color_index),
      .rsp_read_data        (rsp_read_data),
      .rsp_nmi_pulse        (rsp_nmi_pulse),
      .rsp_frame_done       (rsp_frame_done),
      .rsp_rendering_enabled(rsp_rendering_enabled)
   );

   tile_background_video_unit_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_reg_index        (req_reg_index),
      .req_write_data       (req_write_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pixel_valid      (rsp_pixel_valid),
      .rsp_color_index      (rsp_color_index),
      .rsp_read_data        (rsp_read_data),
      .rsp_nmi_pulse        (rsp_nmi_pulse),
      .rsp_frame_done       (rsp_frame_done),
      .rsp_rendering_enabled(rsp_rendering_enabled),
      .error_count          (error_count),
      .outstanding          (outstanding)
   );

   // result side stall, with a long hold-off whenever one is asked for
   initial begin : sink_stall
      forever begin
         @(posedge clock);
         if (hold_served != hold_asked) begin
            hold_served++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < sink_idle_pct);
      end
   end

   // offer one request, with random gaps before it, until it is taken
   task automatic issue(input logic [1:0] op, input logic [2:0] idx, input logic [7:0] data);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_reg_index <= idx;
      req_write_data <= data;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and let every expected result come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // point at start and write count random bytes, step 1
   task automatic fill_block(input logic [15:0] start, input int count,
                             input logic [7:0] bits_kept);
      issue(OP_WRITE, REG_ADDR, start[15:8]);
      issue(OP_WRITE, REG_ADDR, start[7:0]);
      repeat (count) issue(OP_WRITE, REG_DATA, 8'($urandom) & bits_kept);
   endtask

   // tick runs, scratch data streams, control writes and noise
   task automatic mixed_traffic(input int count);
      int          done;
      int          kind;
      int          len;
      logic [15:0] ptr;
      done = 0;
      while (done < count) begin
         kind = $urandom_range(99);
         if (kind < 45) begin
            len = $urandom_range(40, 1);
            repeat (len) issue(OP_TICK, 3'($urandom), 8'($urandom));
            done += len;
         end else if (kind < 75) begin
            len = $urandom_range(STREAM_MAX, 1);
            ptr = SCRATCH_BASE + 16'($urandom_range(STREAM_SPREAD));
            issue(OP_READ, REG_STATUS, 8'($urandom));
            issue(OP_WRITE, REG_ADDR, ptr[15:8]);
            issue(OP_WRITE, REG_ADDR, ptr[7:0]);
            repeat (len) issue($urandom_range(1) ? OP_READ : OP_WRITE, REG_DATA, 8'($urandom));
            done += len + 3;
         end else if (kind < 88) begin
            issue(OP_WRITE, $urandom_range(1) ? REG_CTRL : REG_MASK, 8'($urandom));
            done++;
         end else begin
            // any operation, away from the address and data ports
            issue(2'($urandom), 3'($urandom_range(int'(REG_ADDR) - 1)), 8'($urandom));
            done++;
         end
      end
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      src_idle_pct = 37;
      sink_idle_pct = 81;

      // fill every byte that rendering and the data streams can read
      for (int n = 0; n < NAMETABLES; n++) begin
         fill_block(NAMETABLE_BASE + 16'(n) * NAMETABLE_SPAN, ROW_TILES, TILE_ID_MASK);
         fill_block(NAMETABLE_BASE + 16'(n) * NAMETABLE_SPAN + ATTR_OFFSET, ROW_ATTRS, 8'hFF);
      end
      fill_block(PATTERN_LOW, PATTERN_BYTES, 8'hFF);
      fill_block(PATTERN_HIGH, PATTERN_BYTES, 8'hFF);
      fill_block(PALETTE_BASE, PALETTE_BYTES, 8'hFF);
      fill_block(SCRATCH_BASE, SCRATCH_BYTES, 8'hFF);

      // every register but the data port read once, unused ones return zero
      for (int r = 0; r < int'(REG_DATA); r++) issue(OP_READ, 3'(r), 8'h00);
      // the status register and the unused registers ignore writes
      for (int r = REG_STATUS; r < REG_ADDR; r++) issue(OP_WRITE, 3'(r), 8'hFF);
      // each render enable bit on its own
      issue(OP_WRITE, REG_MASK, 8'h08);
      issue(OP_WRITE, REG_MASK, 8'h10);
      issue(OP_IDLE, REG_DATA, 8'hFF);
      // step 32 from the top of the pointer range: palette bypass, wrap, then the buffer
      issue(OP_WRITE, REG_CTRL, 8'h04);
      issue(OP_WRITE, REG_ADDR, WRAP_ADDR[15:8]);
      issue(OP_WRITE, REG_ADDR, WRAP_ADDR[7:0]);
      issue(OP_WRITE, REG_DATA, 8'($urandom));
      issue(OP_WRITE, REG_ADDR, WRAP_ADDR[15:8]);
      issue(OP_WRITE, REG_ADDR, WRAP_ADDR[7:0]);
      issue(OP_READ, REG_DATA, 8'h00);
      issue(OP_READ, REG_DATA, 8'h00);
      // nmi on, high pattern table, last nametable, fetches at dots 0 and 8
      issue(OP_WRITE, REG_CTRL, 8'h93);
      repeat (9) issue(OP_TICK, REG_DATA, 8'hFF);

      mixed_traffic(RANDOM_PER_PHASE);
      wait_drained();

      // sender idles heavily, receiver lightly
      src_idle_pct = 81;
      sink_idle_pct = 37;
      mixed_traffic(RANDOM_PER_PHASE);
      wait_drained();

      // no idling; a long receiver hold-off while requests keep coming
      src_idle_pct = 0;
      sink_idle_pct = 0;
      hold_asked++;
      mixed_traffic(FILL_BURST);
      mixed_traffic(RANDOM_PER_PHASE);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[tile_background_video_unit] OK");
      end else begin
         $display("[tile_background_video_unit] ERROR");
      end
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin : watchdog
      #2_000_000;
      $display("[tile_background_video_unit] ERROR");
      $finish;
   end

endmodule

// File: tile_background_video_unit.f
+incdir+hdl
hdl/tbvu_pkg.sv
hdl/tile_background_video_unit.sv
tb/sv/tile_background_video_unit_checker.sv
tb/sv/tb.sv
